[hw/rtl/isc_pkg.sv]
package isc_pkg;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    OP_FIRST  = 2'd0,
    OP_SECOND = 2'd1,
    OP_TARGET = 2'd2,
    OP_EVAL   = 2'd3
  } op_t;

  // Row token that walks along the cell chain, one cell per cycle.
  typedef struct packed {
    logic  valid;
    logic  row0;
    byte_t ch;
  } tok_t;

endpackage

[hw/rtl/interleaving_string_check.sv]
// Interleaving check: load items append one byte to the first source (op 0),
// the second source (op 1) or the target (op 2); each load gives no result.
// A load into a full buffer (MAX_LEN bytes per source, 2*MAX_LEN for the
// target) is dropped and sets a sticky overflow flag. An
// evaluate item (op 3) gives one result: interleaved is 1 when the target is
// an order-keeping merge of the two sources, and overflow reports any dropped
// load. Evaluate then empties all buffers and clears the flag. When the lengths
// do not add up the result is ready the cycle after the evaluate is accepted.
// Otherwise the table is computed as a diagonal wavefront through a chain of
// MAX_LEN+1 cells, one table column per cell: row i reaches cell j in step
// i+j (L1, L2 the source lengths), and the result is taken from column L2
// once row L1 has left it. Input is stalled while the wavefront runs; loads
// are still taken while an earlier result waits on output.
module interleaving_string_check #(
  parameter int MAX_LEN = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  isc_pkg::op_t      op,
  input  isc_pkg::byte_t    char_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              interleaved,
  output logic              overflow
);

  import isc_pkg::*;

  localparam int LW  = $clog2(MAX_LEN + 1);                 // source length
  localparam int TLW = $clog2(2 * MAX_LEN + 1);             // target length
  localparam int SW  = $clog2(2 * MAX_LEN + 2);             // wavefront step
  localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1; // source address
  localparam int TAW = $clog2(2 * MAX_LEN);                 // target address

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t         state;
  logic [LW-1:0]  first_len;
  logic [LW-1:0]  second_len;
  logic [TLW-1:0] target_len;
  logic           overflow_flag;
  logic [SW-1:0]  step;

  logic           accept;
  logic           first_we;
  logic           second_we;
  logic           target_we;
  logic           len_match;
  logic [SW-1:0]  last_step;
  byte_t          first_rd;
  byte_t          target_rd;
  logic [MAX_LEN:0] dp;
  tok_t           tok [0:MAX_LEN];

  // Hold input while the wavefront runs, and hold an evaluate while a result
  // still waits to be taken.
  assign in_stall = (state != ST_IDLE) || ((op == OP_EVAL) && out_valid);
  assign accept   = in_valid && !in_stall;

  assign first_we  = accept && (op == OP_FIRST)  && (first_len  < LW'(MAX_LEN));
  assign second_we = accept && (op == OP_SECOND) && (second_len < LW'(MAX_LEN));
  assign target_we = accept && (op == OP_TARGET) && (target_len < TLW'(2 * MAX_LEN));

  assign len_match = (TLW'(first_len) + TLW'(second_len)) == target_len;
  assign last_step = SW'(first_len) + SW'(second_len) + SW'(1);

  // Source and target bytes: read address follows the step, so the byte of
  // index step-1 shows up in the step that consumes it.
  isc_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_first_ram (
    .clk     (clk),
    .wr_en   (first_we),
    .wr_addr (first_len[AW-1:0]),
    .wr_data (char_in),
    .rd_addr (step[AW-1:0]),
    .rd_data (first_rd)
  );

  isc_ram #(.WIDTH(8), .DEPTH(2 * MAX_LEN)) u_target_ram (
    .clk     (clk),
    .wr_en   (target_we),
    .wr_addr (target_len[TAW-1:0]),
    .wr_data (char_in),
    .rd_addr (step[TAW-1:0]),
    .rd_data (target_rd)
  );

  // Row token entering the head cell: row number equals the step.
  assign tok[0].valid = (state == ST_RUN) && (step <= SW'(first_len));
  assign tok[0].row0  = (step == '0);
  assign tok[0].ch    = first_rd;

  // Cell j keeps table column j and, for j >= 1, second-source byte j-1.
  for (genvar j = 0; j <= MAX_LEN; j++) begin : g_cell
    if (j == 0) begin : g_head
      isc_cell #(.HEAD(1'b1)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .tok_in    (tok[0]),
        .left_dp   (tok[0].row0),
        .tbyte     (target_rd),
        .s_wr_en   (1'b0),
        .s_wr_data (char_in),
        .dp        (dp[0]),
        .tok_out   (tok[1])
      );
    end else if (j < MAX_LEN) begin : g_mid
      isc_cell #(.HEAD(1'b0)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .tok_in    (tok[j]),
        .left_dp   (dp[j-1]),
        .tbyte     (target_rd),
        .s_wr_en   (second_we && (second_len == LW'(j - 1))),
        .s_wr_data (char_in),
        .dp        (dp[j]),
        .tok_out   (tok[j+1])
      );
    end else begin : g_tail
      isc_cell #(.HEAD(1'b0)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .tok_in    (tok[j]),
        .left_dp   (dp[j-1]),
        .tbyte     (target_rd),
        .s_wr_en   (second_we && (second_len == LW'(j - 1))),
        .s_wr_data (char_in),
        .dp        (dp[j]),
        .tok_out   ()
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      first_len     <= '0;
      second_len    <= '0;
      target_len    <= '0;
      overflow_flag <= 1'b0;
      step          <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (op)
              OP_FIRST: begin
                if (first_we) first_len <= first_len + LW'(1);
                else          overflow_flag <= 1'b1;
              end
              OP_SECOND: begin
                if (second_we) second_len <= second_len + LW'(1);
                else           overflow_flag <= 1'b1;
              end
              OP_TARGET: begin
                if (target_we) target_len <= target_len + TLW'(1);
                else           overflow_flag <= 1'b1;
              end
              OP_EVAL: begin
                if (len_match) begin
                  state <= ST_RUN;
                  step  <= '0;
                end else begin
                  // Lengths disagree: answer at once and empty the buffers.
                  out_valid     <= 1'b1;
                  interleaved   <= 1'b0;
                  overflow      <= overflow_flag;
                  first_len     <= '0;
                  second_len    <= '0;
                  target_len    <= '0;
                  overflow_flag <= 1'b0;
                end
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_RUN: begin
          step <= step + SW'(1);
          if (step == last_step) begin
            // Last row has left column second_len; take the answer from there.
            out_valid     <= 1'b1;
            interleaved   <= dp[second_len];
            overflow      <= overflow_flag;
            first_len     <= '0;
            second_len    <= '0;
            target_len    <= '0;
            overflow_flag <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/isc_ram.sv]
module isc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/isc_cell.sv]
module isc_cell #(
  parameter bit HEAD = 1'b0
) (
  input  logic           clk,
  input  logic           rst,
  input  isc_pkg::tok_t  tok_in,
  input  logic           left_dp,
  input  isc_pkg::byte_t tbyte,
  input  logic           s_wr_en,
  input  isc_pkg::byte_t s_wr_data,
  output logic           dp,
  output isc_pkg::tok_t  tok_out
);

  import isc_pkg::*;

  logic s_hit;
  logic dp_next;

  // Head cell has no second-source byte; its left input carries the row-0 seed.
  if (HEAD) begin : g_head
    assign s_hit = 1'b1;
  end else begin : g_body
    byte_t s_byte;
    always_ff @(posedge clk) begin
      if (s_wr_en) begin
        s_byte <= s_wr_data;
      end
    end
    assign s_hit = (s_byte == tbyte);
  end

  assign dp_next = (dp & ~tok_in.row0 & (tok_in.ch == tbyte)) | (left_dp & s_hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_in;
    end
    if (tok_in.valid) begin
      dp <= dp_next;
    end
  end

endmodule

[verif/interleaving_string_check_tb.sv]
module interleaving_string_check_tb;
  import isc_pkg::*;

  localparam int MAX_LEN    = 64;
  localparam int TARGET_CAP = 2 * MAX_LEN;
  // Long enough to cover the longest evaluate, with margin on top of that.
  localparam int DRAIN_CYCLES = TARGET_CAP + 16;
  // Quiet cycles allowed with no item moving on either side.
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 220;

  typedef struct packed {
    logic merged;
    logic ovf;
  } verdict_t;

  typedef struct packed {
    op_t   op;
    byte_t ch;
  } item_t;

  typedef struct {
    op_t   op;
    byte_t ch;
    int    reps;
    bit    typed;
    bit    want_merged;
    bit    want_ovf;
  } dir_row_t;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_stall;
  op_t   op;
  byte_t char_in;
  logic  out_valid;
  logic  out_stall;
  logic  interleaved;
  logic  overflow;

  // Shadow copy of the three buffers and the sticky flag.
  byte_t src_first[$];
  byte_t src_second[$];
  byte_t src_target[$];
  bit    ovf_sticky;

  verdict_t pending_verdicts[$];

  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int phase_end;
  int verdicts_seen;
  int merged_count;
  int ovf_count;
  int mismatch_count;
  int hold_left;
  bit hold_done;
  int quiet_cycles;

  interleaving_string_check #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .char_in    (char_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .interleaved(interleaved),
    .overflow   (overflow)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Directed items. Verdicts are typed in only where obvious: empty buffers,
  // length mismatch, overflow, and a plain concatenation at full size.
  localparam int DIR_ROWS = 27;
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_EVAL,   8'h00, 1,              1'b1, 1'b1, 1'b0},  // all empty
    '{OP_FIRST,  8'h00, 1,              1'b0, 1'b0, 1'b0},
    '{OP_EVAL,   8'hFF, 1,              1'b1, 1'b0, 1'b0},  // lengths differ
    '{OP_TARGET, 8'hFF, 1,              1'b0, 1'b0, 1'b0},
    '{OP_EVAL,   8'h00, 1,              1'b1, 1'b0, 1'b0},  // lengths differ
    '{OP_FIRST,  8'h00, 1,              1'b0, 1'b0, 1'b0},
    '{OP_SECOND, 8'hFF, 1,              1'b0, 1'b0, 1'b0},
    '{OP_TARGET, 8'hFF, 1,              1'b0, 1'b0, 1'b0},
    '{OP_TARGET, 8'h00, 1,              1'b0, 1'b0, 1'b0},
    '{OP_EVAL,   8'h5A, 1,              1'b0, 1'b0, 1'b0},
    '{OP_FIRST,  8'h01, 1,              1'b0, 1'b0, 1'b0},
    '{OP_SECOND, 8'h02, 1,              1'b0, 1'b0, 1'b0},
    '{OP_TARGET, 8'h01, 1,              1'b0, 1'b0, 1'b0},
    '{OP_TARGET, 8'h03, 1,              1'b0, 1'b0, 1'b0},
    '{OP_EVAL,   8'h00, 1,              1'b0, 1'b0, 1'b0},
    '{OP_FIRST,  8'hAA, MAX_LEN + 1,    1'b0, 1'b0, 1'b0},  // one past full
    '{OP_EVAL,   8'h00, 1,              1'b1, 1'b0, 1'b1},
    '{OP_SECOND, 8'h55, MAX_LEN + 1,    1'b0, 1'b0, 1'b0},
    '{OP_EVAL,   8'h00, 1,              1'b1, 1'b0, 1'b1},
    '{OP_TARGET, 8'h80, TARGET_CAP + 1, 1'b0, 1'b0, 1'b0},
    '{OP_EVAL,   8'h00, 1,              1'b1, 1'b0, 1'b1},
    '{OP_FIRST,  8'h11, MAX_LEN,        1'b0, 1'b0, 1'b0},  // full, no drop
    '{OP_SECOND, 8'h22, MAX_LEN,        1'b0, 1'b0, 1'b0},
    '{OP_TARGET, 8'h11, MAX_LEN,        1'b0, 1'b0, 1'b0},
    '{OP_TARGET, 8'h22, MAX_LEN,        1'b0, 1'b0, 1'b0},
    '{OP_EVAL,   8'h00, 1,              1'b1, 1'b1, 1'b0},  // first then second
    '{OP_EVAL,   8'hFF, 1,              1'b1, 1'b1, 1'b0}   // cleared again
  };

  // Bottom-up merge table over the kept bytes, one row per first-source byte.
  function automatic bit predict_merge();
    bit row [0:MAX_LEN];
    int i;
    int j;
    byte_t a;
    byte_t t;
    if (src_first.size() + src_second.size() != src_target.size()) return 1'b0;
    row[0] = 1'b1;
    for (j = 1; j <= src_second.size(); j++)
      row[j] = row[j-1] && (src_second[j-1] == src_target[j-1]);
    for (i = 1; i <= src_first.size(); i++) begin
      a = src_first[i-1];
      row[0] = row[0] && (a == src_target[i-1]);
      for (j = 1; j <= src_second.size(); j++) begin
        t = src_target[i+j-1];
        row[j] = (row[j] && a == t) || (row[j-1] && src_second[j-1] == t);
      end
    end
    return row[src_second.size()];
  endfunction

  function automatic int rand_len();
    if ($urandom_range(15) == 0) return $urandom_range(MAX_LEN);
    return $urandom_range(6);
  endfunction

  function automatic byte_t rand_char(input bit wide);
    if (wide) return byte_t'($urandom_range(255));
    return byte_t'(8'h61 + $urandom_range(2));
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR: verdict %0d: %s", verdicts_seen, what);
    mismatch_count++;
  endtask

  // Offer one item, hold it until taken, then advance the shadow buffers.
  task automatic send_item(input op_t o, input byte_t c, input bit typed,
                           input bit want_merged, input bit want_ovf);
    verdict_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    char_in  <= c;
    do @(posedge clk); while (in_stall);
    items_sent++;
    case (o)
      OP_FIRST: begin
        if (src_first.size() < MAX_LEN) src_first.push_back(c);
        else ovf_sticky = 1'b1;
      end
      OP_SECOND: begin
        if (src_second.size() < MAX_LEN) src_second.push_back(c);
        else ovf_sticky = 1'b1;
      end
      OP_TARGET: begin
        if (src_target.size() < TARGET_CAP) src_target.push_back(c);
        else ovf_sticky = 1'b1;
      end
      OP_EVAL: begin
        v.merged = typed ? want_merged : predict_merge();
        v.ovf    = typed ? want_ovf : ovf_sticky;
        pending_verdicts.push_back(v);
        src_first.delete();
        src_second.delete();
        src_target.delete();
        ovf_sticky = 1'b0;
      end
    endcase
  endtask

  // One evaluate's worth of loads: mostly true merges of two random sources,
  // some with a corrupted byte, a wrong length or an overfull buffer, and a
  // few runs of pure noise. Loads to the three buffers arrive interleaved.
  task automatic send_sequence();
    byte_t a[$];
    byte_t b[$];
    byte_t t[$];
    item_t seq[$];
    int kind;
    int la;
    int lb;
    int ia;
    int ib;
    int it;
    int k;
    int pick;
    bit wide;
    item_t itm;
    kind = $urandom_range(99);
    wide = ($urandom_range(99) < 40);
    if (kind < 8) begin
      repeat ($urandom_range(12)) begin
        itm.op = op_t'($urandom_range(3));
        itm.ch = byte_t'($urandom_range(255));
        seq.push_back(itm);
      end
    end else begin
      la = rand_len();
      lb = rand_len();
      if (kind < 11) begin
        case ($urandom_range(2))
          0: la = MAX_LEN + $urandom_range(1, 3);
          1: lb = MAX_LEN + $urandom_range(1, 3);
          default: begin
            la = MAX_LEN;
            lb = MAX_LEN;
          end
        endcase
      end
      repeat (la) a.push_back(rand_char(wide));
      repeat (lb) b.push_back(rand_char(wide));
      ia = 0;
      ib = 0;
      while (ia < la || ib < lb) begin
        if (ib >= lb || (ia < la && $urandom_range(1))) t.push_back(a[ia++]);
        else t.push_back(b[ib++]);
      end
      if (kind < 11 && la == MAX_LEN && lb == MAX_LEN) begin
        repeat ($urandom_range(1, 2)) t.push_back(rand_char(wide));
      end else if (kind < 23 && t.size() > 0) begin
        k = $urandom_range(t.size() - 1);
        t[k] = t[k] ^ byte_t'(1 << $urandom_range(7));
      end else if (kind < 33) begin
        if (t.size() > 0 && $urandom_range(1)) t.delete($urandom_range(t.size() - 1));
        else t.push_back(rand_char(wide));
      end
      ia = 0;
      ib = 0;
      it = 0;
      while (ia < a.size() || ib < b.size() || it < t.size()) begin
        pick = $urandom_range(2);
        if (pick == 0 && ia < a.size()) begin
          itm.op = OP_FIRST;
          itm.ch = a[ia++];
          seq.push_back(itm);
        end else if (pick == 1 && ib < b.size()) begin
          itm.op = OP_SECOND;
          itm.ch = b[ib++];
          seq.push_back(itm);
        end else if (pick == 2 && it < t.size()) begin
          itm.op = OP_TARGET;
          itm.ch = t[it++];
          seq.push_back(itm);
        end
      end
    end
    itm.op = OP_EVAL;
    itm.ch = byte_t'($urandom_range(255));
    seq.push_back(itm);
    foreach (seq[n]) send_item(seq[n].op, seq[n].ch, 1'b0, 1'b0, 1'b0);
  endtask

  // Receiver: check each taken verdict against the oldest one pending, and
  // stall at random. Once, hold the output off for a long stretch so that a
  // verdict backs up and the next evaluate stalls the input.
  always @(posedge clk) begin : rx_side
    verdict_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("verdict with none pending");
        end else begin
          want = pending_verdicts.pop_front();
          if (interleaved !== want.merged)
            report_mismatch($sformatf("interleaved %b, predicted %b",
                                      interleaved, want.merged));
          if (overflow !== want.ovf)
            report_mismatch($sformatf("overflow %b, predicted %b",
                                      overflow, want.ovf));
        end
        if (interleaved === 1'b1) merged_count <= merged_count + 1;
        if (overflow === 1'b1) ovf_count <= ovf_count + 1;
        verdicts_seen <= verdicts_seen + 1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && verdicts_seen == 20) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    op             = OP_FIRST;
    char_in        = '0;
    out_stall      = 1'b0;
    ovf_sticky     = 1'b0;
    items_sent     = 0;
    phase_end      = 0;
    verdicts_seen  = 0;
    merged_count   = 0;
    ovf_count      = 0;
    mismatch_count = 0;
    hold_left      = 0;
    hold_done      = 1'b0;
    send_idle_pct  = 16;
    recv_idle_pct  = 50;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].reps)
        send_item(dir_rows[r].op, dir_rows[r].ch, dir_rows[r].typed,
                  dir_rows[r].want_merged, dir_rows[r].want_ovf);
    end

    // Sender busy, receiver often stalled; then swap; then run flat out.
    phase_end = items_sent + PHASE_ITEMS;
    while (items_sent < phase_end) send_sequence();
    send_idle_pct = 50;
    recv_idle_pct = 16;
    phase_end = items_sent + PHASE_ITEMS;
    while (items_sent < phase_end) send_sequence();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    phase_end = items_sent + PHASE_ITEMS;
    while (items_sent < phase_end) send_sequence();
    in_valid <= 1'b0;

    // Drain: wait for all verdicts, then watch for strays.
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items; checked %0d verdicts (%0d interleaved, %0d overflow).",
             items_sent, verdicts_seen, merged_count, ovf_count);
    $display("Covered empty, mismatched, corrupted, full-size and overfull buffers.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/isc_pkg.sv
hw/rtl/isc_ram.sv
hw/rtl/isc_cell.sv
hw/rtl/interleaving_string_check.sv
verif/interleaving_string_check_tb.sv
